@@ rtl/core/swc_pkg.sv @@
// swc_pkg: shared types, codes and tables of the square wave sound channel
// no dependencies; imported by all core modules
`timescale 1ns / 1ps

package swc_pkg;

  // event codes carried in func
  localparam logic [2:0] FUNC_READ     = 3'd0;
  localparam logic [2:0] FUNC_WRITE    = 3'd1;
  localparam logic [2:0] FUNC_PERIOD   = 3'd2;
  localparam logic [2:0] FUNC_LENGTH   = 3'd3;
  localparam logic [2:0] FUNC_ENVELOPE = 3'd4;
  localparam logic [2:0] FUNC_SWEEP    = 3'd5;

  // register indexes
  localparam logic [2:0] REG_SWEEP   = 3'd0;
  localparam logic [2:0] REG_LENDUTY = 3'd1;
  localparam logic [2:0] REG_VOLENV  = 3'd2;
  localparam logic [2:0] REG_PLOW    = 3'd3;
  localparam logic [2:0] REG_PHIGH   = 3'd4;
  localparam int unsigned REG_COUNT  = 5;
  localparam logic [2:0] REG_LIMIT   = 3'(REG_COUNT);

  // counter constants
  localparam logic [6:0]  LENGTH_FULL = 7'd64;
  localparam logic [11:0] FREQ_SPAN   = 12'd2048;
  localparam logic [3:0]  VOLUME_MAX  = 4'd15;

  // one input beat
  typedef struct packed {
    logic [2:0] func;
    logic [2:0] register_index;
    logic [7:0] write_data;
  } swc_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample_level;
    logic       channel_on;
  } swc_result_t;

  // 12.5, 25, 50 and 75 percent duty patterns
  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'h01;
      2'd1:    pat = 8'h81;
      2'd2:    pat = 8'h87;
      default: pat = 8'h7E;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/swc_if.sv @@
// swc_evt_if and swc_res_if: valid/ready channels of the sound channel
// no dependencies
`timescale 1ns / 1ps

interface swc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] register_index;
  logic [7:0] write_data;

  modport source (output valid, output func, output register_index, output write_data,
                  input ready);
  modport sink   (input valid, input func, input register_index, input write_data,
                  output ready);
endinterface

interface swc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] sample_level;
  logic       channel_on;

  modport source (output valid, output read_data, output sample_level, output channel_on,
                  input ready);
  modport sink   (input valid, input read_data, input sample_level, input channel_on,
                  output ready);
endinterface

@@ rtl/core/square_wave_sound_channel_unit.sv @@
// square_wave_sound_channel_unit: top level of the square wave sound channel
// depends on swc_pkg, swc_if, swc_state_unit, swc_out_reg
//
// Usage: evt_i takes one event beat (func, register_index, write_data): a register
// read or write, or a period, length, envelope or sweep tick. res_o returns one beat
// per event with read_data, sample_level and channel_on as they stand after it.
// res_o.valid rises once the event has passed both registers: the event is captured in
// the input register, decoded against the channel state in one pass, and the result
// is captured in the output register when it has room. One event is accepted every
// cycle while res_o does not stall; the rate is set by the state update in swc_state_unit.
// When res_o stalls, the output register holds its beat and the input register holds
// the next event; evt_i.ready drops only once both are full and resumes at once.
// Reset clears all channel registers and counters, turns the channel off and
// empties both registers.
`timescale 1ns / 1ps

module square_wave_sound_channel_unit
  import swc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  swc_evt_if.sink   evt_i,
  swc_res_if.source res_o
);

  logic        in_vld_q;
  swc_item_t   in_q;
  logic        space;
  logic        step;
  swc_result_t result;

  // the held event advances when the output register has room
  assign step        = in_vld_q && space;
  assign evt_i.ready = !in_vld_q || space;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      in_q.func           <= evt_i.func;
      in_q.register_index <= evt_i.register_index;
      in_q.write_data     <= evt_i.write_data;
    end
  end

  // channel state and event decode
  swc_state_unit u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  // result register
  swc_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .space_o  (space),
    .res_o    (res_o)
  );

endmodule

@@ rtl/core/swc_state_unit.sv @@
// swc_state_unit: channel registers and running state, one event per step
// depends on swc_pkg
`timescale 1ns / 1ps

module swc_state_unit
  import swc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  swc_item_t   item_i,
  output swc_result_t result_o
);

  logic [7:0]  regs_q [REG_COUNT];
  logic [7:0]  regs_d [REG_COUNT];
  logic [6:0]  len_q, len_d;
  logic [13:0] div_q, div_d;
  logic [2:0]  duty_q, duty_d;
  logic        pwr_q, pwr_d;
  logic [3:0]  vol_q, vol_d;
  logic [2:0]  env_q, env_d;
  logic [10:0] shadow_q, shadow_d;
  logic        sw_act_q, sw_act_d;
  logic [2:0]  sw_tmr_q, sw_tmr_d;

  logic [7:0]  rd;
  logic [10:0] freq;
  logic [11:0] calc1, calc2;
  logic [7:0]  pat;

  // next sweep frequency, bit 11 flags overflow
  function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [7:0] sw);
    logic [10:0] delta;
    delta = sh >> sw[2:0];
    if (sw[3]) begin
      return {1'b0, sh - delta};
    end
    return {1'b0, sh} + {1'b0, delta};
  endfunction

  // divider reload, (2048 - f) * 4
  function automatic logic [13:0] reload(input logic [10:0] f);
    logic [11:0] span;
    span = FREQ_SPAN - {1'b0, f};
    return {span, 2'b00};
  endfunction

  // event decode and state update
  always_comb begin
    regs_d   = regs_q;
    len_d    = len_q;
    div_d    = div_q;
    duty_d   = duty_q;
    pwr_d    = pwr_q;
    vol_d    = vol_q;
    env_d    = env_q;
    shadow_d = shadow_q;
    sw_act_d = sw_act_q;
    sw_tmr_d = sw_tmr_q;
    rd       = 8'd0;
    freq     = 11'd0;
    calc1    = 12'd0;
    calc2    = 12'd0;
    unique case (item_i.func)
      FUNC_READ: begin
        if (item_i.register_index < REG_LIMIT) begin
          rd = regs_q[item_i.register_index];
        end
      end
      FUNC_WRITE: begin
        if (item_i.register_index < REG_LIMIT) begin
          regs_d[item_i.register_index] = item_i.write_data;
          if (item_i.register_index == REG_LENDUTY) begin
            len_d = LENGTH_FULL - {1'b0, item_i.write_data[5:0]};
          end else if (item_i.register_index == REG_PHIGH && item_i.write_data[7]) begin
            // trigger
            freq     = {regs_d[REG_PHIGH][2:0], regs_d[REG_PLOW]};
            pwr_d    = 1'b1;
            div_d    = reload(freq);
            vol_d    = regs_d[REG_VOLENV][7:4];
            if (len_q == 7'd0) begin
              len_d = LENGTH_FULL;
            end
            duty_d   = 3'd0;
            env_d    = regs_d[REG_VOLENV][2:0];
            shadow_d = freq;
            sw_tmr_d = regs_d[REG_SWEEP][6:4];
            sw_act_d = (|regs_d[REG_SWEEP][6:4]) || (|regs_d[REG_SWEEP][2:0]);
            if (|regs_d[REG_SWEEP][2:0]) begin
              calc1 = sweep_calc(freq, regs_d[REG_SWEEP]);
              if (calc1[11]) begin
                pwr_d = 1'b0;
              end
            end
          end
        end
      end
      FUNC_PERIOD: begin
        if (regs_q[REG_VOLENV][7:3] == 5'd0) begin
          pwr_d = 1'b0;
        end
        if (pwr_d) begin
          if (div_q <= 14'd1) begin
            freq   = {regs_q[REG_PHIGH][2:0], regs_q[REG_PLOW]};
            div_d  = reload(freq);
            duty_d = duty_q + 3'd1;
          end else begin
            div_d = div_q - 14'd1;
          end
        end
      end
      FUNC_LENGTH: begin
        if (regs_q[REG_PHIGH][6] && len_q != 7'd0) begin
          len_d = len_q - 7'd1;
          if (len_d == 7'd0) begin
            pwr_d = 1'b0;
          end
        end
      end
      FUNC_ENVELOPE: begin
        if (regs_q[REG_VOLENV][2:0] != 3'd0) begin
          if (env_q > 3'd1) begin
            env_d = env_q - 3'd1;
          end else begin
            env_d = regs_q[REG_VOLENV][2:0];
            if (regs_q[REG_VOLENV][3]) begin
              if (vol_q < VOLUME_MAX) begin
                vol_d = vol_q + 4'd1;
              end
            end else if (vol_q != 4'd0) begin
              vol_d = vol_q - 4'd1;
            end
          end
        end
      end
      FUNC_SWEEP: begin
        if (sw_act_q && regs_q[REG_SWEEP][6:4] != 3'd0) begin
          if (sw_tmr_q > 3'd1) begin
            sw_tmr_d = sw_tmr_q - 3'd1;
          end else begin
            sw_tmr_d = regs_q[REG_SWEEP][6:4];
            calc1    = sweep_calc(shadow_q, regs_q[REG_SWEEP]);
            if (calc1[11]) begin
              pwr_d = 1'b0;
            end else if (|regs_q[REG_SWEEP][2:0]) begin
              // write back, then check once more
              shadow_d          = calc1[10:0];
              regs_d[REG_PLOW]  = calc1[7:0];
              regs_d[REG_PHIGH] = {regs_q[REG_PHIGH][7:3], calc1[10:8]};
              calc2             = sweep_calc(calc1[10:0], regs_q[REG_SWEEP]);
              if (calc2[11]) begin
                pwr_d = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result after the event
  always_comb begin
    pat                   = duty_pattern(regs_d[REG_LENDUTY][7:6]);
    result_o.read_data    = rd;
    result_o.sample_level = (pwr_d && pat[duty_d]) ? vol_d : 4'd0;
    result_o.channel_on   = pwr_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= 8'd0;
      end
      len_q    <= 7'd0;
      div_q    <= 14'd0;
      duty_q   <= 3'd0;
      pwr_q    <= 1'b0;
      vol_q    <= 4'd0;
      env_q    <= 3'd0;
      shadow_q <= 11'd0;
      sw_act_q <= 1'b0;
      sw_tmr_q <= 3'd0;
    end else if (step_i) begin
      regs_q   <= regs_d;
      len_q    <= len_d;
      div_q    <= div_d;
      duty_q   <= duty_d;
      pwr_q    <= pwr_d;
      vol_q    <= vol_d;
      env_q    <= env_d;
      shadow_q <= shadow_d;
      sw_act_q <= sw_act_d;
      sw_tmr_q <= sw_tmr_d;
    end
  end

endmodule

@@ rtl/core/swc_out_reg.sv @@
// swc_out_reg: result register that drives the result channel
// depends on swc_pkg and swc_res_if
`timescale 1ns / 1ps

module swc_out_reg
  import swc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  swc_result_t result_i,
  output logic        space_o,
  swc_res_if.source   res_o
);

  logic        vld_q;
  swc_result_t res_q;

  // free when empty or when the held beat leaves this cycle
  assign space_o = !vld_q || res_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (space_o) begin
      vld_q <= load_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= result_i;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.read_data    = res_q.read_data;
  assign res_o.sample_level = res_q.sample_level;
  assign res_o.channel_on   = res_q.channel_on;

endmodule
